// ===== src/qenc_pkg.sv =====
// Shared types and constants for the quadrature encoder positioner.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package qenc_pkg;

    localparam int TENTHS_W   = 17;
    localparam int PPR_W      = 24;
    localparam int PROD_W     = TENTHS_W + PPR_W;
    localparam int ACC_W      = PROD_W + 1;
    localparam int IVL_W      = 16;
    localparam int POS_W      = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_PPR = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IVL = 4'd1;

    localparam logic [PPR_W-1:0] PPR_RESET = 24'd14000;
    localparam logic [IVL_W-1:0] IVL_RESET = 16'd100;

    // Tenths of a degree per revolution, and that value less one.
    localparam logic signed [ACC_W-1:0] STEP_SCALE  = 42'sd3600;
    localparam logic signed [ACC_W-1:0] STEP_MARGIN = 42'sd3599;

    typedef enum logic [2:0] {
        REQ_NONE = 3'd0,
        REQ_MOVE = 3'd1,
        REQ_CW   = 3'd2,
        REQ_CCW  = 3'd3,
        REQ_STOP = 3'd4,
        REQ_ZERO = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        MODE_STOP = 2'd0,
        MODE_CW   = 2'd1,
        MODE_CCW  = 2'd2
    } t_mode;

    typedef struct packed {
        logic                       enc_a;
        logic                       enc_b;
        logic                       ms_tick;
        t_req                       req;
        logic signed [TENTHS_W-1:0] tenths;
    } t_item;

    typedef struct packed {
        t_item             item;
        logic [PROD_W-1:0] prod;
    } t_staged;

    // Handshake enables that step the pipeline stages.
    typedef struct packed {
        logic ld_in;
        logic ld_mul;
        logic ld_out;
    } t_pipe_ctl;

endpackage

`default_nettype wire

// ===== src/qenc_target.sv =====
// Input register and move target product stage.
// Depends on qenc_pkg for the item types and widths.
`timescale 1ns / 1ps
`default_nettype none

module qenc_target
    import qenc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire t_pipe_ctl        i_ctl,
    input  wire t_item            i_item,
    input  wire logic [PPR_W-1:0] i_ppr,
    output t_staged               o_staged
);

    t_item             r_item;
    t_staged           r_staged;
    logic [TENTHS_W-1:0] mag;

    // Magnitude of the angle; the most negative code still fits unsigned.
    always_comb begin
        if (r_item.tenths[TENTHS_W-1]) begin
            mag = TENTHS_W'(0) - r_item.tenths;
        end else begin
            mag = r_item.tenths;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_in) begin
            r_item <= i_item;
        end
        if (i_ctl.ld_mul) begin
            r_staged.item <= r_item;
            r_staged.prod <= PROD_W'(mag) * PROD_W'(i_ppr);
        end
    end

    assign o_staged = r_staged;

endmodule

`default_nettype wire

// ===== src/qenc_track.sv =====
// Position, velocity and drive state with the result register.
// Depends on qenc_pkg; takes the staged item with its target product.
`timescale 1ns / 1ps
`default_nettype none

module qenc_track
    import qenc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_pipe_ctl        i_ctl,
    input  wire t_staged          i_staged,
    input  wire logic [IVL_W-1:0] i_interval,
    output logic [POS_W-1:0]      o_position,
    output logic [POS_W-1:0]      o_velocity,
    output t_mode                 o_mode,
    output logic                  o_moving,
    output logic                  o_done
);

    logic                    r_last_a, n_last_a;
    logic                    r_last_b, n_last_b;
    logic [POS_W-1:0]        r_count, n_count;
    logic [POS_W-1:0]        r_latch, n_latch;
    logic [POS_W-1:0]        r_speed, n_speed;
    logic [IVL_W-1:0]        r_ticks, n_ticks;
    logic                    r_active, n_active;
    logic                    r_done, n_done;
    t_mode                   r_mode, n_mode;
    logic signed [ACC_W-1:0] r_goal, n_goal;
    logic signed [ACC_W-1:0] r_up, n_up;
    logic signed [ACC_W-1:0] r_dn, n_dn;

    logic a_chg, b_chg, phase, inc, dec;
    t_item item;

    assign item  = i_staged.item;
    assign a_chg = item.enc_a != r_last_a;
    assign b_chg = item.enc_b != r_last_b;
    assign phase = item.enc_a ^ item.enc_b;
    // Both channels changing at once cancel out.
    assign inc = ((a_chg & phase) | (b_chg & ~phase)) & ~(a_chg & b_chg);
    assign dec = ((a_chg & ~phase) | (b_chg & phase)) & ~(a_chg & b_chg);

    // The move is tracked as distance times 3600 against the exact product,
    // so the truncated target never has to be divided out: travelled reaches
    // trunc(P / 3600) exactly when 3600 * travelled + 3599 >= P.
    always_comb begin
        n_last_a = item.enc_a;
        n_last_b = item.enc_b;
        n_count  = r_count;
        n_latch  = r_latch;
        n_speed  = r_speed;
        n_ticks  = r_ticks;
        n_active = r_active;
        n_mode   = r_mode;
        n_goal   = r_goal;
        n_up     = r_up;
        n_dn     = r_dn;
        n_done   = 1'b0;

        if (inc) begin
            n_count = r_count + POS_W'(1);
            n_up    = r_up + STEP_SCALE;
            n_dn    = r_dn - STEP_SCALE;
        end else if (dec) begin
            n_count = r_count - POS_W'(1);
            n_up    = r_up - STEP_SCALE;
            n_dn    = r_dn + STEP_SCALE;
        end

        if (item.ms_tick) begin
            n_ticks = r_ticks + IVL_W'(1);
            if (n_ticks >= i_interval) begin
                n_speed = n_count - r_latch;
                n_latch = n_count;
                n_ticks = '0;
            end
        end

        case (item.req)
            REQ_MOVE: begin
                n_mode   = item.tenths[TENTHS_W-1] ? MODE_CCW : MODE_CW;
                n_goal   = $signed({1'b0, i_staged.prod});
                n_up     = STEP_MARGIN;
                n_dn     = STEP_MARGIN;
                n_active = 1'b1;
            end
            REQ_CW: begin
                n_mode   = MODE_CW;
                n_active = 1'b0;
            end
            REQ_CCW: begin
                n_mode   = MODE_CCW;
                n_active = 1'b0;
            end
            REQ_STOP: begin
                n_mode   = MODE_STOP;
                n_active = 1'b0;
            end
            REQ_ZERO: begin
                n_count = '0;
                n_latch = '0;
            end
            default: begin
            end
        endcase

        if (n_active && (n_up >= n_goal || n_dn >= n_goal)) begin
            n_active = 1'b0;
            n_mode   = MODE_STOP;
            n_done   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_a <= 1'b0;
            r_last_b <= 1'b0;
            r_count  <= '0;
            r_latch  <= '0;
            r_speed  <= '0;
            r_ticks  <= '0;
            r_active <= 1'b0;
            r_done   <= 1'b0;
        end else if (i_ctl.ld_out) begin
            r_last_a <= n_last_a;
            r_last_b <= n_last_b;
            r_count  <= n_count;
            r_latch  <= n_latch;
            r_speed  <= n_speed;
            r_ticks  <= n_ticks;
            r_active <= n_active;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_STOP;
        end else if (i_ctl.ld_out) begin
            r_mode <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_out) begin
            r_goal <= n_goal;
            r_up   <= n_up;
            r_dn   <= n_dn;
        end
    end

    assign o_position = r_count;
    assign o_velocity = r_speed;
    assign o_mode     = r_mode;
    assign o_moving   = r_active;
    assign o_done     = r_done;

endmodule

`default_nettype wire

// ===== src/quadrature_encoder_motor_positioner.sv =====
// Quadrature x4 decoder with velocity latch and degree-move positioner.
// Three register stages: input word, target product, result. A word passes
// through the input and the single 17x24 product register into the result;
// one word per cycle is sustained while the output is not stalled.
// Synchronous active-low reset stops the drive and clears position, velocity
// and the pipeline; configuration returns to 14000 pulses and 100 ticks.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_encoder_motor_positioner
    import qenc_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic                       i_enc_a,
    input  wire logic                       i_enc_b,
    input  wire logic                       i_ms_tick,
    input  wire logic [2:0]                 i_req_type,
    input  wire logic signed [TENTHS_W-1:0] i_move_tenths_degrees,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic signed [POS_W-1:0]         o_position,
    output logic signed [POS_W-1:0]         o_velocity,
    output logic                            o_drive_in1,
    output logic                            o_drive_in2,
    output logic                            o_moving,
    output logic                            o_move_done
);

    logic [PPR_W-1:0] r_ppr;
    logic [IVL_W-1:0] r_ivl;
    logic             r_v_in, r_v_mul, r_v_out;
    t_pipe_ctl        ctl;
    t_item            item;
    t_staged          staged;
    t_mode            mode;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] velocity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppr <= PPR_RESET;
            r_ivl <= IVL_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_PPR) begin
                r_ppr <= i_cfg_data[PPR_W-1:0];
            end else if (i_cfg_idx == CFG_IVL) begin
                r_ivl <= i_cfg_data[IVL_W-1:0];
            end
        end
    end

    // Each stage loads when it is empty or its word moves on.
    always_comb begin
        ctl.ld_out = r_v_mul & (~r_v_out | i_out_ready);
        ctl.ld_mul = r_v_in & (~r_v_mul | ctl.ld_out);
        ctl.ld_in  = i_in_valid & o_in_ready;
    end

    assign o_in_ready = ~r_v_in | ctl.ld_mul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in  <= 1'b0;
            r_v_mul <= 1'b0;
            r_v_out <= 1'b0;
        end else begin
            if (ctl.ld_in) begin
                r_v_in <= 1'b1;
            end else if (ctl.ld_mul) begin
                r_v_in <= 1'b0;
            end
            if (ctl.ld_mul) begin
                r_v_mul <= 1'b1;
            end else if (ctl.ld_out) begin
                r_v_mul <= 1'b0;
            end
            if (ctl.ld_out) begin
                r_v_out <= 1'b1;
            end else if (i_out_ready) begin
                r_v_out <= 1'b0;
            end
        end
    end

    always_comb begin
        item.enc_a   = i_enc_a;
        item.enc_b   = i_enc_b;
        item.ms_tick = i_ms_tick;
        item.req     = t_req'(i_req_type);
        item.tenths  = i_move_tenths_degrees;
    end

    qenc_target u_target (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_item   (item),
        .i_ppr    (r_ppr),
        .o_staged (staged)
    );

    qenc_track u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_staged   (staged),
        .i_interval (r_ivl),
        .o_position (position),
        .o_velocity (velocity),
        .o_mode     (mode),
        .o_moving   (o_moving),
        .o_done     (o_move_done)
    );

    assign o_out_valid = r_v_out;
    assign o_position  = $signed(position);
    assign o_velocity  = $signed(velocity);
    assign o_drive_in1 = (mode == MODE_CCW);
    assign o_drive_in2 = (mode == MODE_CW);

endmodule

`default_nettype wire

// ===== bench/quadrature_encoder_motor_positioner_test.sv =====
// Self-checking bench for the quadrature encoder positioner: a directed table, then random
// encoder walks, moves and requests under several register settings and handshake stalls.
// Depends on qenc_pkg and quadrature_encoder_motor_positioner.
`timescale 1ns / 1ps

module quadrature_encoder_motor_positioner_test;
    import qenc_pkg::*;

    localparam logic [2:0] REQ_SPARE6     = 3'd6;
    localparam logic [2:0] REQ_SPARE7     = 3'd7;
    localparam longint     TENTHS_PER_REV = 3600;
    localparam int         SETTLE_CYCLES  = 6;

    typedef struct packed {
        logic                       enc_a;
        logic                       enc_b;
        logic                       ms_tick;
        logic [2:0]                 req;
        logic signed [TENTHS_W-1:0] tenths;
    } enc_word_t;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] velocity;
        logic             drive_in1;
        logic             drive_in2;
        logic             moving;
        logic             move_done;
    } motion_status_t;

    typedef struct packed {
        enc_word_t      word;
        logic           known;
        motion_status_t want;
    } stim_row_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic                       i_enc_a = 1'b0;
    logic                       i_enc_b = 1'b0;
    logic                       i_ms_tick = 1'b0;
    logic [2:0]                 i_req_type = 3'd0;
    logic signed [TENTHS_W-1:0] i_move_tenths_degrees = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic signed [POS_W-1:0]    o_position;
    logic signed [POS_W-1:0]    o_velocity;
    logic                       o_drive_in1;
    logic                       o_drive_in2;
    logic                       o_moving;
    logic                       o_move_done;

    quadrature_encoder_motor_positioner dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_enc_a               (i_enc_a),
        .i_enc_b               (i_enc_b),
        .i_ms_tick             (i_ms_tick),
        .i_req_type            (i_req_type),
        .i_move_tenths_degrees (i_move_tenths_degrees),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_position            (o_position),
        .o_velocity            (o_velocity),
        .o_drive_in1           (o_drive_in1),
        .o_drive_in2           (o_drive_in2),
        .o_moving              (o_moving),
        .o_move_done           (o_move_done)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state, mirroring the block after reset.
    logic [PPR_W-1:0] ppr_reg        = PPR_RESET;
    logic [IVL_W-1:0] ivl_reg        = IVL_RESET;
    logic             seen_a         = 1'b0;
    logic             seen_b         = 1'b0;
    logic [POS_W-1:0] count          = '0;
    logic [POS_W-1:0] count_at_latch = '0;
    logic [POS_W-1:0] speed          = '0;
    logic [IVL_W-1:0] ticks          = '0;
    logic             move_on        = 1'b0;
    logic [POS_W-1:0] move_origin    = '0;
    logic [POS_W-1:0] move_goal      = '0;
    t_mode            mode           = MODE_STOP;

    motion_status_t pending_status[$];
    int             tx_gap_pct = 13;
    int             rx_stall_pct = 65;
    int             mismatches = 0;
    int             words_sent = 0;
    int             moves_finished = 0;
    int             latches_seen = 0;
    logic [1:0]     walk_phase = 2'd0;
    logic           walk_up = 1'b1;

    function automatic motion_status_t advance_positioner(input enc_word_t w);
        logic [POS_W-1:0] delta;
        logic [POS_W-1:0] diff;
        logic [POS_W-1:0] span;
        longint           tenths_l;
        longint           ppr_l;
        longint           goal_l;
        motion_status_t   r;
        delta = '0;
        r = '0;
        // Per channel: up when the new levels fit the x4 forward sequence, else down.
        if (w.enc_a != seen_a) delta += (w.enc_a == !w.enc_b) ? 32'd1 : 32'hFFFF_FFFF;
        if (w.enc_b != seen_b) delta += (w.enc_b == w.enc_a) ? 32'd1 : 32'hFFFF_FFFF;
        count += delta;
        seen_a = w.enc_a;
        seen_b = w.enc_b;
        if (w.ms_tick) begin
            ticks = ticks + 16'd1;
            if (ticks >= ivl_reg) begin
                speed = count - count_at_latch;
                count_at_latch = count;
                ticks = '0;
                latches_seen++;
            end
        end
        case (w.req)
            REQ_MOVE: begin
                tenths_l = $signed(w.tenths);
                ppr_l = ppr_reg;
                goal_l = (tenths_l * ppr_l) / TENTHS_PER_REV;
                if (goal_l >= 0) begin
                    mode = MODE_CW;
                    move_goal = goal_l[POS_W-1:0];
                end else begin
                    mode = MODE_CCW;
                    move_goal = 32'(-goal_l);
                end
                move_origin = count;
                move_on = 1'b1;
            end
            REQ_CW: begin
                mode = MODE_CW;
                move_on = 1'b0;
            end
            REQ_CCW: begin
                mode = MODE_CCW;
                move_on = 1'b0;
            end
            REQ_STOP: begin
                mode = MODE_STOP;
                move_on = 1'b0;
            end
            REQ_ZERO: begin
                // Shift the origin so that a running move keeps its distance.
                move_origin -= count;
                count = '0;
                count_at_latch = '0;
            end
            default: ;
        endcase
        diff = count - move_origin;
        span = diff[POS_W-1] ? -diff : diff;
        if (move_on && span >= move_goal) begin
            move_on = 1'b0;
            mode = MODE_STOP;
            r.move_done = 1'b1;
            moves_finished++;
        end
        r.position = count;
        r.velocity = speed;
        r.drive_in1 = (mode == MODE_CCW);
        r.drive_in2 = (mode == MODE_CW);
        r.moving = move_on;
        return r;
    endfunction

    function automatic stim_row_t plain_row(input logic a, input logic b, input logic tick,
                                            input logic [2:0] req,
                                            input logic signed [TENTHS_W-1:0] tenths);
        stim_row_t row;
        row = '0;
        row.word = '{enc_a: a, enc_b: b, ms_tick: tick, req: req, tenths: tenths};
        return row;
    endfunction

    // Velocity is zero in every known row: no latch happens at the reset interval.
    function automatic stim_row_t known_row(input logic a, input logic b, input logic tick,
                                            input logic [2:0] req,
                                            input logic signed [TENTHS_W-1:0] tenths,
                                            input logic [POS_W-1:0] pos, input logic in1,
                                            input logic in2, input logic mov,
                                            input logic done);
        stim_row_t row;
        row = plain_row(a, b, tick, req, tenths);
        row.known = 1'b1;
        row.want = '{position: pos, velocity: '0, drive_in1: in1, drive_in2: in2,
                     moving: mov, move_done: done};
        return row;
    endfunction

    task automatic send_word(input enc_word_t w, input logic use_known,
                             input motion_status_t known_status);
        motion_status_t predicted;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_enc_a <= w.enc_a;
        i_enc_b <= w.enc_b;
        i_ms_tick <= w.ms_tick;
        i_req_type <= w.req;
        i_move_tenths_degrees <= w.tenths;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = advance_positioner(w);
        pending_status.push_back(use_known ? known_status : predicted);
        words_sent++;
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PPR) ppr_reg = val;
        else if (idx == CFG_IVL) ivl_reg = val[IVL_W-1:0];
    endtask

    task automatic configure(input logic [PPR_W-1:0] ppr, input logic [IVL_W-1:0] ivl);
        drain();
        write_reg(CFG_PPR, ppr);
        write_reg(CFG_IVL, 24'(ivl));
    endtask

    // Mostly clean quadrature walks with occasional reversals, holds and glitches,
    // plus a sprinkling of moves sized so that many of them finish.
    task automatic random_words(input int n);
        enc_word_t w;
        int        pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 5) walk_up = !walk_up;
            if (pick < 80) begin
                walk_phase = walk_up ? walk_phase + 2'd1 : walk_phase - 2'd1;
            end else if (pick >= 90) begin
                walk_phase = 2'($urandom_range(3));
            end
            w.enc_a = walk_phase[0] ^ walk_phase[1];
            w.enc_b = walk_phase[1];
            w.ms_tick = ($urandom_range(99) < 30);
            w.tenths = TENTHS_W'($urandom);
            pick = $urandom_range(199);
            if (pick < 6) begin
                w.req = REQ_MOVE;
                pick = $urandom_range(99);
                if (pick < 60) begin
                    w.tenths = TENTHS_W'($urandom_range(20));
                end else if (pick < 90) begin
                    w.tenths = TENTHS_W'($urandom_range(36000));
                end
                if (pick < 90 && $urandom_range(1)) w.tenths = -w.tenths;
            end else if (pick < 8) begin
                w.req = REQ_CW;
            end else if (pick < 10) begin
                w.req = REQ_CCW;
            end else if (pick < 12) begin
                w.req = REQ_STOP;
            end else if (pick < 14) begin
                w.req = REQ_ZERO;
            end else if (pick < 15) begin
                w.req = $urandom_range(1) ? REQ_SPARE6 : REQ_SPARE7;
            end else begin
                w.req = REQ_NONE;
            end
            send_word(w, 1'b0, '0);
        end
    endtask

    task automatic compare_field(input string name, input logic [POS_W-1:0] want,
                                 input logic [POS_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name,
                     $signed(want), $signed(got));
            mismatches++;
        end
    endtask

    always @(negedge i_clk) i_out_ready <= ($urandom_range(99) >= rx_stall_pct);

    always @(posedge i_clk) begin
        motion_status_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_status.size() == 0) begin
                $display("%0t ns: result word with nothing expected, position %0d",
                         $time, o_position);
                mismatches++;
            end else begin
                want = pending_status.pop_front();
                compare_field("position", want.position, o_position);
                compare_field("velocity", want.velocity, o_velocity);
                compare_field("drive_in1", 32'(want.drive_in1), 32'(o_drive_in1));
                compare_field("drive_in2", 32'(want.drive_in2), 32'(o_drive_in2));
                compare_field("moving", 32'(want.moving), 32'(o_moving));
                compare_field("move_done", 32'(want.move_done), 32'(o_move_done));
            end
        end
    end

    initial begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        stim_row_t directed_rows[$];
        directed_rows = '{
            known_row(0, 0, 0, REQ_NONE, 0, 0, 0, 0, 0, 0),
            // One full forward cycle of the x4 sequence.
            known_row(1, 0, 0, REQ_NONE, 0, 1, 0, 0, 0, 0),
            known_row(1, 1, 0, REQ_NONE, 0, 2, 0, 0, 0, 0),
            known_row(0, 1, 0, REQ_NONE, 0, 3, 0, 0, 0, 0),
            known_row(0, 0, 0, REQ_NONE, 0, 4, 0, 0, 0, 0),
            // Both channels change at once: the two rules cancel.
            known_row(1, 1, 1, REQ_NONE, 0, 4, 0, 0, 0, 0),
            known_row(1, 1, 0, REQ_CW, 0, 4, 0, 1, 0, 0),
            known_row(1, 1, 0, REQ_CCW, 0, 4, 1, 0, 0, 0),
            // A zero target finishes on the same word.
            known_row(1, 1, 0, REQ_MOVE, 0, 4, 0, 0, 0, 1),
            plain_row(1, 1, 0, REQ_MOVE, 1),
            plain_row(0, 1, 1, REQ_NONE, -17'sd1),
            plain_row(0, 0, 0, REQ_NONE, 0),
            plain_row(1, 0, 0, REQ_NONE, 0),
            plain_row(1, 0, 0, REQ_MOVE, -17'sd1),
            plain_row(1, 1, 1, REQ_NONE, 0),
            // Position cleared while a move runs.
            plain_row(1, 1, 0, REQ_ZERO, 0),
            plain_row(1, 0, 0, REQ_NONE, 0),
            plain_row(1, 0, 0, REQ_NONE, 0),
            plain_row(1, 0, 1, REQ_MOVE, 17'sh0FFFF),
            plain_row(1, 0, 0, REQ_CW, 0),
            plain_row(1, 0, 0, REQ_MOVE, 17'sh10000),
            plain_row(1, 0, 0, REQ_STOP, 0),
            plain_row(0, 1, 1, REQ_SPARE6, -17'sd1),
            plain_row(0, 1, 0, REQ_SPARE7, 17'sh0AAAA),
            plain_row(0, 1, 0, REQ_MOVE, 36000),
            plain_row(1, 0, 1, REQ_MOVE, -36000)
        };
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].known, directed_rows[i].want);

        // Zero settings: every target is zero and every tick latches.
        configure('0, '0);
        random_words(150);
        configure(24'd1, 16'd1);
        random_words(450);

        tx_gap_pct = 65;
        rx_stall_pct = 13;
        configure(24'hFF_FFFF, 16'hFFFF);
        random_words(350);
        configure(24'd3600, 16'd5);
        random_words(400);

        tx_gap_pct = 0;
        rx_stall_pct = 0;
        configure(24'd14000, 16'd3);
        random_words(200);
        drain();
        random_words(250);

        drain();
        $display("Summary: %0d words over six register settings, %0d moves finished,",
                 words_sent, moves_finished);
        $display("         %0d velocity latches, %0d field mismatches.",
                 latches_seen, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
